>>> src/abo_pkg.sv
// Shared constants for the ARGB over-blend pipeline.
`default_nettype none
package abo_pkg;

  localparam int unsigned ChW = 8;
  localparam logic [ChW-1:0] ChMax = 8'hFF;

  // Pipeline stage indexes; a stage register loads when its enable is high.
  localparam int unsigned StgIn      = 0;   // first products
  localparam int unsigned StgProd    = 1;   // cd*t, out alpha
  localparam int unsigned StgDiv255  = 2;   // reciprocal multiply for /255
  localparam int unsigned StgNum     = 3;   // numerator sum
  localparam int unsigned StgDivFirst = 4;  // first quotient bit (and saturation)
  localparam int unsigned DivBits    = 8;
  localparam int unsigned StgDivLast = StgDivFirst + DivBits - 1;
  localparam int unsigned StgOut     = StgDivLast + 1;
  localparam int unsigned NumStages  = StgOut + 1;

  // floor(x/255) = (x * Recip16) >> Recip16Sh, exact for x < 2^16
  localparam logic [15:0] Recip16   = 16'h8081;
  localparam int unsigned Recip16Sh = 23;
  // floor(x/255) = (x * Recip24) >> Recip24Sh, exact for x < 2^24
  localparam logic [23:0] Recip24   = 24'h808081;
  localparam int unsigned Recip24Sh = 31;

  localparam int unsigned NumW = 17;  // c_s*sa + floor(c_d*t/255) <= 130050

  typedef logic [NumStages-1:0] stage_en_t;
  typedef logic [ChW-1:0] chan_t;

endpackage
`default_nettype wire

>>> src/abo_alpha.sv
// Combined alpha path: da*(255-sa), divide by 255, add sa, then delay line.
`default_nettype none
module abo_alpha import abo_pkg::*; (
  input  wire                     clk_i,
  input  stage_en_t               en_i,
  input  chan_t                   sa_i,
  input  chan_t                   da_i,
  output logic [15:0]             t_o,
  output chan_t [StgOut-1:StgProd] oa_o
);

  chan_t       sa_q;
  logic [15:0] t_q;
  logic [31:0] t_recip;
  chan_t [StgOut-1:StgProd] oa_q;

  assign t_recip = t_q * Recip16;

  always_ff @(posedge clk_i) begin
    if (en_i[StgIn]) begin
      sa_q <= sa_i;
      t_q  <= da_i * (ChMax - sa_i);
    end
  end

  // out alpha never exceeds 255, so the sum fits in eight bits
  always_ff @(posedge clk_i) begin
    if (en_i[StgProd]) begin
      oa_q[StgProd] <= sa_q + t_recip[Recip16Sh +: ChW];
    end
  end

  for (genvar s = StgProd + 1; s < StgOut; s++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        oa_q[s] <= oa_q[s-1];
      end
    end
  end

  assign t_o  = t_q;
  assign oa_o = oa_q;

endmodule
`default_nettype wire

>>> src/abo_lane.sv
// One color channel: numerator, then bit-per-stage restoring divide by alpha.
`default_nettype none
module abo_lane import abo_pkg::*; (
  input  wire                   clk_i,
  input  stage_en_t             en_i,
  input  chan_t                 cs_i,
  input  chan_t                 cd_i,
  input  chan_t                 sa_i,
  input  logic [15:0]           t_i,
  input  chan_t [DivBits-1:0]   oa_i,   // divisor seen by each divide step
  output chan_t                 q_o
);

  logic [15:0]     csa0_q, csa1_q, csa2_q;
  chan_t           cd0_q;
  logic [23:0]     p1_q;
  logic [47:0]     p_recip;
  logic [15:0]     d2_q;
  logic [NumW-1:0] num3_q;

  logic [NumW-1:0] rem_in [DivBits];
  logic [NumW-1:0] rem_q  [DivBits];
  chan_t           quo_in [DivBits];
  chan_t           quo_q  [DivBits];
  logic            sat_in [DivBits];
  logic            sat_q  [DivBits];

  assign p_recip = p1_q * Recip24;

  always_ff @(posedge clk_i) begin
    if (en_i[StgIn]) begin
      csa0_q <= cs_i * sa_i;
      cd0_q  <= cd_i;
    end
    if (en_i[StgProd]) begin
      csa1_q <= csa0_q;
      p1_q   <= cd0_q * t_i;
    end
    if (en_i[StgDiv255]) begin
      csa2_q <= csa1_q;
      d2_q   <= p_recip[Recip24Sh +: 16];
    end
    if (en_i[StgNum]) begin
      num3_q <= {1'b0, csa2_q} + {1'b0, d2_q};
    end
  end

  for (genvar j = 0; j < DivBits; j++) begin : g_div
    localparam int unsigned Bit = DivBits - 1 - j;
    logic [NumW-1:0] trial;

    if (j == 0) begin : g_first
      // quotient above 255 exactly when num >= oa * 256
      assign rem_in[j] = num3_q;
      assign quo_in[j] = '0;
      assign sat_in[j] = (num3_q >= (NumW'(oa_i[j]) << DivBits));
    end else begin : g_next
      assign rem_in[j] = rem_q[j-1];
      assign quo_in[j] = quo_q[j-1];
      assign sat_in[j] = sat_q[j-1];
    end

    assign trial = NumW'(oa_i[j]) << Bit;

    always_ff @(posedge clk_i) begin
      if (en_i[StgDivFirst + j]) begin
        sat_q[j] <= sat_in[j];
        if (rem_in[j] >= trial) begin
          rem_q[j] <= rem_in[j] - trial;
          quo_q[j] <= quo_in[j] | (chan_t'(1) << Bit);
        end else begin
          rem_q[j] <= rem_in[j];
          quo_q[j] <= quo_in[j];
        end
      end
    end
  end

  assign q_o = sat_q[DivBits-1] ? ChMax : quo_q[DivBits-1];

endmodule
`default_nettype wire

>>> src/argb_alpha_blend_over.sv
// Top level: Porter-Duff over of straight-alpha ARGB8888 pixels, three color lanes.
//
// Usage:
//   Slave channel s_axis_*: one word per source/destination pixel pair,
//   tdata[31:0] = src_color, tdata[63:32] = dst_color.
//   Master channel m_axis_*: one word per input word, tdata[31:0] = out_color.
//   An accepted word reaches tvalid on the master side through 13 stages
//   (first products, cd*t and out alpha, /255 reciprocal multiply, numerator,
//   eight restoring divide steps of one quotient bit each, output register).
//   Throughput: one pixel per clock without output stalls; every stage is registered.
//   Red, green and blue each run in their own lane beside a shared alpha
//   path; the output stage merges them and forces zero when alpha is zero.
//   Stall: each stage takes a new word when it is empty or its successor
//   moves, so bubbles collapse and input is still accepted while the output
//   waits, until all 13 stages hold words.
//   Reset: clears all stage valid bits; no word is in flight afterwards.
`default_nettype none
module argb_alpha_blend_over import abo_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  wire  [63:0]  s_axis_tdata_i,   // [31:0] src_color, [63:32] dst_color
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  output logic [31:0]  m_axis_tdata_o    // [31:0] out_color
);

  stage_en_t valid_q, valid_d, en;
  logic [31:0] src, dst;
  logic [15:0] t;
  chan_t [StgOut-1:StgProd] oa_pipe;
  chan_t q_r, q_g, q_b;
  logic [31:0] out_q;

  assign src = s_axis_tdata_i[31:0];
  assign dst = s_axis_tdata_i[63:32];

  // ready chain: a stage loads when empty or when its word moves on
  always_comb begin
    en[StgOut] = ~valid_q[StgOut] | m_axis_tready_i;
    for (int k = StgOut - 1; k >= 0; k--) begin
      en[k] = ~valid_q[k] | en[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (en[StgIn]) valid_d[StgIn] = s_axis_tvalid_i;
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) valid_d[k] = valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  abo_alpha u_alpha (
    .clk_i (clk_i),
    .en_i  (en),
    .sa_i  (src[31:24]),
    .da_i  (dst[31:24]),
    .t_o   (t),
    .oa_o  (oa_pipe)
  );

  abo_lane u_lane_r (
    .clk_i (clk_i),
    .en_i  (en),
    .cs_i  (src[23:16]),
    .cd_i  (dst[23:16]),
    .sa_i  (src[31:24]),
    .t_i   (t),
    .oa_i  (oa_pipe[StgDivLast-1:StgDivFirst-1]),
    .q_o   (q_r)
  );

  abo_lane u_lane_g (
    .clk_i (clk_i),
    .en_i  (en),
    .cs_i  (src[15:8]),
    .cd_i  (dst[15:8]),
    .sa_i  (src[31:24]),
    .t_i   (t),
    .oa_i  (oa_pipe[StgDivLast-1:StgDivFirst-1]),
    .q_o   (q_g)
  );

  abo_lane u_lane_b (
    .clk_i (clk_i),
    .en_i  (en),
    .cs_i  (src[7:0]),
    .cd_i  (dst[7:0]),
    .sa_i  (src[31:24]),
    .t_i   (t),
    .oa_i  (oa_pipe[StgDivLast-1:StgDivFirst-1]),
    .q_o   (q_b)
  );

  // merge: zero alpha means both pixels were transparent, so the word is zero
  always_ff @(posedge clk_i) begin
    if (en[StgOut]) begin
      if (oa_pipe[StgDivLast] == '0) begin
        out_q <= '0;
      end else begin
        out_q <= {oa_pipe[StgDivLast], q_r, q_g, q_b};
      end
    end
  end

  assign s_axis_tready_o = en[StgIn];
  assign m_axis_tvalid_o = valid_q[StgOut];
  assign m_axis_tdata_o  = out_q;

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (&valid_q))
    else $error("input blocked while a pipeline stage is empty");

  a_accept_fills_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> valid_q[StgIn])
    else $error("accepted word did not enter the first stage");

  a_zero_alpha_zero_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[31:24] == 8'h00) |-> (m_axis_tdata_o == 32'h0))
    else $error("transparent result carries color bits");

  a_move_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[StgDivLast] && valid_q[StgOut] && !m_axis_tready_i) |=>
      (valid_q[StgDivLast] && valid_q[StgOut]))
    else $error("word lost at the output merge");

endmodule
`default_nettype wire

>>> bench/tb_argb_alpha_blend_over.sv
// Testbench for the ARGB over-blend pipeline: directed pixel table, then random pixel pairs.
`timescale 1ns / 100ps
module tb_argb_alpha_blend_over import abo_pkg::*;;

  localparam int NDir     = 18;
  localparam int NRand    = 700;
  localparam int NItems   = NDir + NRand;
  localparam int PauseAt  = NDir + 350;  // sender waits here for the pipe to drain
  localparam int HoldAt   = 200;         // receiver back-pressure after this many words
  localparam int HoldCyc  = 80;
  localparam int DrainCyc = 20;
  localparam int CycLimit = 200000;

  // One directed stimulus row; want is only used when typed is set.
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] want;
    logic        typed;
  } pixel_row_t;

  localparam pixel_row_t DirRows [NDir] = '{
    '{32'h00FFFFFF, 32'h00FFFFFF, 32'h00000000, 1'b1},  // both transparent -> all zero
    '{32'h00000000, 32'h00000000, 32'h00000000, 1'b1},
    '{32'hFF123456, 32'h80ABCDEF, 32'hFF123456, 1'b1},  // opaque source wins
    '{32'hFFFFFFFF, 32'hFF000000, 32'hFFFFFFFF, 1'b1},
    '{32'hFF000000, 32'hFFFFFFFF, 32'hFF000000, 1'b1},
    '{32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF, 1'b1},
    '{32'h00FFFFFF, 32'hFF102030, 32'hFF102030, 1'b1},  // clear source shows dest
    '{32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1},
    '{32'h00AABBCC, 32'h80112233, 32'h80112233, 1'b1},
    '{32'h00FFFFFF, 32'h01FFFFFF, 32'h01FFFFFF, 1'b1},
    '{32'h01000000, 32'h00FFFFFF, 32'h01000000, 1'b1},
    '{32'h01FFFFFF, 32'h01FFFFFF, 32'h0, 1'b0},         // alpha truncation -> colour saturates
    '{32'h01FFFFFF, 32'hFFFFFFFF, 32'h0, 1'b0},
    '{32'h80FF0000, 32'h800000FF, 32'h0, 1'b0},
    '{32'hFEFFFFFF, 32'hFE000000, 32'h0, 1'b0},
    '{32'h7F808080, 32'h7F808080, 32'h0, 1'b0},
    '{32'hAA55AA55, 32'h55AA55AA, 32'h0, 1'b0},
    '{32'h55AA55AA, 32'hAA55AA55, 32'h0, 1'b0}
  };

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [63:0] s_data  = '0;   // [31:0] src_color, [63:32] dst_color
  logic        m_ready = 1'b1;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;  // [31:0] out_color

  logic [31:0] pixel_q [$];  // blended pixels still owed by the pipe
  int          err_cnt    = 0;
  int          cyc_cnt    = 0;
  int          stall_cyc  = 0;
  int          zero_alpha = 0;
  int          words_out  = 0;
  bit          rx_holding = 1'b0;

  argb_alpha_blend_over u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // Straight-alpha over: out alpha first, then each colour divided by it.
  function automatic logic [31:0] blend_over(input logic [31:0] src, input logic [31:0] dst);
    int unsigned full, sa, da, t, oa, num, quo;
    logic [31:0] pix;
    full = ChMax;
    sa   = src[31:24];
    da   = dst[31:24];
    t    = full - sa;
    oa   = sa + (da * t) / full;
    pix  = '0;
    if (oa != 0) begin
      pix[31:24] = oa[7:0];
      for (int ch = 0; ch < 3; ch++) begin
        num = src[8*ch +: 8] * sa + (dst[8*ch +: 8] * da * t) / full;
        quo = num / oa;
        if (quo > full) quo = full;
        pix[8*ch +: 8] = quo[7:0];
      end
    end
    return pix;
  endfunction

  // Alphas lean on the edges where truncation and the zero case live.
  function automatic chan_t pick_alpha();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01;
      3: return 8'hFE;
      default: return chan_t'($urandom);
    endcase
  endfunction

  function automatic chan_t pick_chan();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return ChMax;
      default: return chan_t'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_pair();
    logic [31:0] src, dst;
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    src = {pick_alpha(), pick_chan(), pick_chan(), pick_chan()};
    dst = {pick_alpha(), pick_chan(), pick_chan(), pick_chan()};
    return {dst, src};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_cnt < 40)
      $display("ERROR @%0t: %s: got %08h, want %08h", $time, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CycLimit) begin
      $display("Timeout after %0d cycles, %0d words still owed", cyc_cnt, pixel_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Output side check and input stall count.
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && s_valid && !s_axis_tready_o) stall_cyc++;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      words_out++;
      if (pixel_q.size() == 0) begin
        report_mismatch("out_color with nothing owed", m_axis_tdata_o, 32'h0);
      end else begin
        want = pixel_q.pop_front();
        if (m_axis_tdata_o !== want) report_mismatch("out_color", m_axis_tdata_o, want);
      end
    end
  end

  // Receiver: random stalls in stretches, plus one long hold-off.
  initial begin
    int  served, gap;
    bit  rx_idle;
    served  = 0;
    rx_idle = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (served % 40 == 0) rx_idle = ($urandom_range(0, 2) != 0);
      if (served == HoldAt) begin
        rx_holding = 1'b1;
        m_ready <= 1'b0;
        repeat (HoldCyc) @(posedge clk_i);
        rx_holding = 1'b0;
        m_ready <= 1'b1;
      end else begin
        gap = rx_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
          m_ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
          m_ready <= 1'b1;
        end
      end
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_ready));
      served++;
    end
  end

  // Reset, sender and end of run.
  initial begin
    int          gap;
    bit          tx_idle;
    logic [63:0] word;
    logic [31:0] want;
    tx_idle = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NItems; i++) begin
      if (i < NDir) begin
        word = {DirRows[i].dst, DirRows[i].src};
        want = DirRows[i].typed ? DirRows[i].want : blend_over(word[31:0], word[63:32]);
      end else begin
        word = rand_pair();
        want = blend_over(word[31:0], word[63:32]);
      end
      if (i % 32 == 0) tx_idle = ($urandom_range(0, 2) != 0);

      if (i == NDir || i == PauseAt) begin
        // let the pipe run dry before going on
        s_valid <= 1'b0;
        do @(posedge clk_i); while (pixel_q.size() != 0);
      end else begin
        gap = (tx_idle && !rx_holding) ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
          s_valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      s_valid <= 1'b1;
      s_data  <= word;
      do @(posedge clk_i); while (!s_axis_tready_o);
      pixel_q.push_back(want);
      if (word[31:24] == 8'h00 && word[63:56] == 8'h00) zero_alpha++;
    end
    s_valid <= 1'b0;

    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);
    if (pixel_q.size() != 0) report_mismatch("words never delivered", 32'h0, pixel_q[0]);

    $display("Blended %0d pixel pairs (%0d from the table, %0d random, %0d fully transparent).",
             words_out, NDir, NRand, zero_alpha);
    $display("Input side stalled %0d cycles under output back-pressure; %0d mismatches.",
             stall_cyc, err_cnt);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
